// File: design/well512_random_generator_top_macros.svh
// assertion macros shared by the checker
// clock and reset are taken from the scope of the use
`ifndef WELL512_RANDOM_GENERATOR_TOP_MACROS_SVH
`define WELL512_RANDOM_GENERATOR_TOP_MACROS_SVH

// cond seen at one edge implies expr at the next edge
`define WELL512_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

// expr must hold at the edge that follows a reset cycle
`define WELL512_ASSERT_POST_RESET(label, expr, msg) \
   label: assert property (@(posedge clock) reset |=> (expr)) \
      else $error(msg);

`endif

// File: design/well512_pkg.sv
`default_nettype none

package well512_pkg;

   localparam int RING_DEPTH = 16;
   localparam int POS_W      = 4;
   localparam int WORD_W     = 32;

   localparam logic [WORD_W-1:0] TEMPER = 32'hDA44_2D24;

   // ring offsets relative to the current position
   localparam logic [POS_W-1:0] OFS_M1   = 4'd13;
   localparam logic [POS_W-1:0] OFS_M2   = 4'd9;
   localparam logic [POS_W-1:0] OFS_BACK = 4'd15;
   localparam logic [POS_W-1:0] POS_LAST = 4'd15;

   localparam logic ACT_RESEED   = 1'b0;
   localparam logic ACT_GENERATE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_RA,
      ST_RC1,
      ST_RC2,
      ST_RA2,
      ST_WR
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [POS_W-1:0]  waddr;
      logic [WORD_W-1:0] wdata;
      logic [POS_W-1:0]  raddr;
   } ram_req_type;

   typedef struct packed {
      logic              load;
      logic [WORD_W-1:0] word;
   } result_type;

endpackage

`default_nettype wire

// File: design/well512_random_generator_top.sv
// channel  | dir | beat contents
// req      | in  | tuser[0] action (0 reseed, 1 generate), tdata[31:0] seed_value
// rsp      | out | tdata[31:0] random_word
//
// a generate beat passes through RC1, RC2, RA2 and WR before the next beat can be taken,
// set by the four reads and two writes on the ring memory, which has one read and one write port
// a reseed beat does sixteen seed writes, each followed by a full step
// reset is synchronous; the ring reads as all zero until each word is written
// a new request is taken while a finished word still waits in the output register;
// the next word then holds in the last step until rsp_tready frees that register
`default_nettype none

module well512_random_generator_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // [31:0] seed_value
   input  wire logic [0:0]  req_tuser,  // [0] action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata   // [31:0] random_word
);

   well512_pkg::ram_req_type       ram_req;
   well512_pkg::result_type        result;
   logic [well512_pkg::WORD_W-1:0] rd_data;
   logic                           res_ready;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [well512_pkg::WORD_W-1:0] rsp_data_ff, rsp_data_in;

   well512_ring_ram u_ring (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   well512_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tuser[0]),
      .req_seed   (req_tdata),
      .res_ready  (res_ready),
      .result     (result),
      .ram_req    (ram_req),
      .rd_data    (rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (result.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// File: design/well512_ring_ram.sv
`default_nettype none

module well512_ring_ram (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire well512_pkg::ram_req_type            ram_req,
   output logic [well512_pkg::WORD_W-1:0]           rd_data
);

   logic [well512_pkg::WORD_W-1:0] mem [well512_pkg::RING_DEPTH];
   logic [well512_pkg::WORD_W-1:0] rdata_ff;
   logic [well512_pkg::RING_DEPTH-1:0] valid_ff;
   logic                           rvalid_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
      rdata_ff <= mem[ram_req.raddr];
   end

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (ram_req.wr_en) begin
            valid_ff[ram_req.waddr] <= 1'b1;
         end
         rvalid_ff <= valid_ff[ram_req.raddr];
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

`default_nettype wire

// File: design/well512_engine.sv
`default_nettype none

module well512_engine (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_action,
   input  wire logic [well512_pkg::WORD_W-1:0]    req_seed,
   input  wire logic                              res_ready,
   output well512_pkg::result_type                result,
   output well512_pkg::ram_req_type               ram_req,
   input  wire logic [well512_pkg::WORD_W-1:0]    rd_data
);

   well512_pkg::state_type state_ff, state_in;

   logic [well512_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [well512_pkg::POS_W-1:0]  idx_ff, idx_in;
   logic                           seeding_ff, seeding_in;
   logic [well512_pkg::WORD_W-1:0] seed_ff, seed_in;
   logic [well512_pkg::WORD_W-1:0] a_ff, a_in;
   logic [well512_pkg::WORD_W-1:0] b_ff, b_in;
   logic [well512_pkg::WORD_W-1:0] c_ff, c_in;
   logic [well512_pkg::WORD_W-1:0] d_ff, d_in;

   logic                           accept;
   logic                           advance;
   logic [well512_pkg::WORD_W-1:0] c_now;
   logic [well512_pkg::WORD_W-1:0] new_a;
   logic [well512_pkg::WORD_W-1:0] new_back;

   assign accept  = req_valid && (state_ff == well512_pkg::ST_IDLE);
   // a generated word waits in the last state until the output register frees up
   assign advance = seeding_ff || res_ready;

   assign c_now    = rd_data ^ (rd_data >> 11);
   assign new_a    = b_ff ^ c_now;
   assign new_back = rd_data ^ b_ff ^ d_ff ^ (rd_data << 2) ^ (b_ff << 18) ^ (c_ff << 28);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         well512_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_action == well512_pkg::ACT_GENERATE) ?
                          well512_pkg::ST_RC1 : well512_pkg::ST_SEED;
            end
         end
         well512_pkg::ST_SEED: state_in = well512_pkg::ST_RA;
         well512_pkg::ST_RA:   state_in = well512_pkg::ST_RC1;
         well512_pkg::ST_RC1:  state_in = well512_pkg::ST_RC2;
         well512_pkg::ST_RC2:  state_in = well512_pkg::ST_RA2;
         well512_pkg::ST_RA2:  state_in = well512_pkg::ST_WR;
         well512_pkg::ST_WR: begin
            if (advance) begin
               if (seeding_ff && (idx_ff != well512_pkg::POS_LAST)) begin
                  state_in = well512_pkg::ST_SEED;
               end else begin
                  state_in = well512_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = well512_pkg::ST_IDLE;
      endcase
   end

   // outputs: memory port, result and handshake
   always_comb begin
      ram_req       = '0;
      ram_req.raddr = pos_ff;
      result.load   = 1'b0;
      result.word   = new_back;
      req_ready     = 1'b0;
      unique case (state_ff)
         well512_pkg::ST_IDLE: req_ready = 1'b1;
         well512_pkg::ST_SEED: begin
            ram_req.wr_en = 1'b1;
            ram_req.waddr = idx_ff;
            ram_req.wdata = seed_ff + {{(well512_pkg::WORD_W-well512_pkg::POS_W){1'b0}}, idx_ff};
         end
         well512_pkg::ST_RA:  ram_req.raddr = pos_ff;
         well512_pkg::ST_RC1: ram_req.raddr = pos_ff + well512_pkg::OFS_M1;
         well512_pkg::ST_RC2: ram_req.raddr = pos_ff + well512_pkg::OFS_M2;
         well512_pkg::ST_RA2: begin
            ram_req.raddr = pos_ff + well512_pkg::OFS_BACK;
            ram_req.wr_en = 1'b1;
            ram_req.waddr = pos_ff;
            ram_req.wdata = new_a;
         end
         well512_pkg::ST_WR: begin
            // keep reading the word behind the position so it holds while stalled
            ram_req.raddr = pos_ff + well512_pkg::OFS_BACK;
            ram_req.wr_en = advance;
            ram_req.waddr = pos_ff + well512_pkg::OFS_BACK;
            ram_req.wdata = new_back;
            result.load   = advance && !seeding_ff;
         end
         default: ram_req = '0;
      endcase
   end

   // datapath registers
   always_comb begin
      pos_in     = pos_ff;
      idx_in     = idx_ff;
      seeding_in = seeding_ff;
      seed_in    = seed_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      c_in       = c_ff;
      d_in       = d_ff;
      if (accept) begin
         seeding_in = (req_action == well512_pkg::ACT_RESEED);
         seed_in    = req_seed;
         idx_in     = '0;
         if (req_action == well512_pkg::ACT_RESEED) begin
            pos_in = '0;
         end
      end
      case (state_ff)
         well512_pkg::ST_RC1: a_in = rd_data;
         well512_pkg::ST_RC2: b_in = a_ff ^ rd_data ^ (a_ff << 16) ^ (rd_data << 15);
         well512_pkg::ST_RA2: begin
            c_in = c_now;
            d_in = new_a ^ ((new_a << 5) & well512_pkg::TEMPER);
         end
         well512_pkg::ST_WR: begin
            if (advance) begin
               pos_in = pos_ff + well512_pkg::OFS_BACK;
               if (seeding_ff) begin
                  idx_in = idx_ff + well512_pkg::POS_W'(1);
                  if (idx_ff == well512_pkg::POS_LAST) begin
                     pos_in     = '0;
                     seeding_in = 1'b0;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= well512_pkg::ST_IDLE;
         pos_ff     <= '0;
         idx_ff     <= '0;
         seeding_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         idx_ff     <= idx_in;
         seeding_ff <= seeding_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_ff <= seed_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
   end

endmodule

`default_nettype wire

// File: design/well512_checker.sv
`default_nettype none
`include "well512_random_generator_top_macros.svh"

module well512_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [0:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // a stalled result beat keeps its word
   `WELL512_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp beat dropped or changed while stalled")

   // each accepted request moves the engine out of idle, so no two requests in a row
   `WELL512_ASSERT_NEXT(a_req_spacing, req_tvalid && req_tready, !req_tready, "request taken on consecutive cycles")

   // a reseed produces no result word
   `WELL512_ASSERT_NEXT(a_seed_silent, req_tvalid && req_tready && !req_tuser[0] && !rsp_tvalid, !rsp_tvalid, "result appeared after reseed")

   // the output register comes out of reset empty
   `WELL512_ASSERT_POST_RESET(a_reset_empty, !rsp_tvalid, "rsp_tvalid high right after reset")

endmodule

bind well512_random_generator_top well512_checker u_well512_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
